// ----- rtl/affine_point_transform_unit_defines.svh -----
// assertion macros shared by the affine point transform rtl
`ifndef AFFINE_POINT_TRANSFORM_UNIT_DEFINES_SVH
`define AFFINE_POINT_TRANSFORM_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define APTU_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("aptu check failed");

// next-cycle implication, checked out of reset
`define APTU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("aptu check failed");

`endif

// ----- rtl/aptu_pkg.sv -----
// types, constants and helpers of the affine point transform unit
`timescale 1ns / 1ps
package aptu_pkg;

    localparam int MAX_DIMS  = 4;
    localparam int FRAC_BITS = 16;
    localparam int NROWS     = MAX_DIMS + 1;
    localparam int COEF_W    = 32;
    localparam int DIM_W     = 3;
    localparam int ROW_W     = 3;
    localparam int COL_W     = 2;
    localparam int PROD_W    = 2 * COEF_W;
    localparam int SUM_W     = PROD_W + $clog2(MAX_DIMS);
    localparam int TOT_W     = SUM_W + 1;
    localparam int CFG_IDX_W = 2;
    localparam int WORD_W    = COEF_W * NROWS;

    localparam logic [0:0] MODE_LOAD  = 1'b0;
    localparam logic [0:0] MODE_POINT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_IN_DIMS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_DIMS = 2'd1;

    localparam logic [DIM_W-1:0] DIMS_RESET = 3'd3;

    localparam logic [COEF_W-1:0] RES_MAX = 32'h7fff_ffff;
    localparam logic [COEF_W-1:0] RES_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [0:0]               mode;
        logic [ROW_W-1:0]         coeff_row;
        logic [COL_W-1:0]         coeff_col;
        logic signed [COEF_W-1:0] coeff_value;
        logic signed [COEF_W-1:0] comp0;
        logic signed [COEF_W-1:0] comp1;
        logic signed [COEF_W-1:0] comp2;
        logic signed [COEF_W-1:0] comp3;
    } t_in_req;

    typedef struct packed {
        logic signed [COEF_W-1:0] result_value;
        logic [COL_W-1:0]         column;
        logic                     last;
        logic                     saturated;
    } t_out_req;

    // one column word of the store: all rows of one matrix column
    typedef logic [NROWS-1:0][COEF_W-1:0] t_word;

    typedef struct packed {
        logic                             load;
        logic [COL_W-1:0]                 col;
        logic                             last;
        logic [DIM_W-1:0]                 id;
        logic [ROW_W-1:0]                 row;
        logic [COEF_W-1:0]                value;
        logic [MAX_DIMS-1:0][COEF_W-1:0]  comp;
    } t_issue;

    function automatic logic [DIM_W-1:0] clamp_dims(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        r = d;
        if (d == '0) begin
            r = DIM_W'(1);
        end else if (d > DIM_W'(MAX_DIMS)) begin
            r = DIM_W'(MAX_DIMS);
        end
        return r;
    endfunction

endpackage

// ----- rtl/aptu_ram.sv -----
// generic single-write single-read ram with registered read
`timescale 1ns / 1ps
module aptu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                                     i_clk,
    input  logic                                     i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                         i_wr_data,
    input  logic                                     i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/aptu_issue.sv -----
// request register and column sequencer of the affine point transform unit
`timescale 1ns / 1ps
`include "affine_point_transform_unit_defines.svh"
module aptu_issue
    import aptu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  t_in_req          i_req,
    input  logic [DIM_W-1:0] i_in_dims,
    input  logic [DIM_W-1:0] i_out_dims,
    input  logic             i_issue_ok,
    output logic             o_go,
    output t_issue           o_iss
);

    logic             r_valid;
    t_in_req          r_req;
    logic [COL_W-1:0] r_col;

    logic [DIM_W-1:0] id;
    logic [DIM_W-1:0] od;
    logic             is_load;
    logic             last;
    logic             done;
    logic             accept;

    assign id      = clamp_dims(i_in_dims);
    assign od      = clamp_dims(i_out_dims);
    assign is_load = (r_req.mode == MODE_LOAD);
    assign last    = (DIM_W'(r_col) == od - DIM_W'(1));
    assign done    = is_load || last;
    assign o_go    = r_valid && i_issue_ok;
    assign o_req_ready = !r_valid || (o_go && done);
    assign accept  = i_req_valid && o_req_ready;

    always_comb begin
        o_iss       = '0;
        o_iss.load  = is_load;
        o_iss.col   = is_load ? r_req.coeff_col : r_col;
        o_iss.last  = last;
        o_iss.id    = id;
        o_iss.row   = r_req.coeff_row;
        o_iss.value = r_req.coeff_value;
        o_iss.comp  = {r_req.comp3, r_req.comp2, r_req.comp1, r_req.comp0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_col   <= '0;
        end else if (accept) begin
            r_valid <= 1'b1;
            r_col   <= '0;
        end else if (o_go && done) begin
            r_valid <= 1'b0;
        end else if (o_go) begin
            r_col <= r_col + COL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
    end

    `APTU_ASSERT_IMPLY(a_col_in_range, o_go && !is_load, DIM_W'(r_col) < od)
    `APTU_ASSERT_NEXT(a_point_steps, o_go && !is_load && !last, r_valid && r_col == $past(r_col) + COL_W'(1))

endmodule

// ----- rtl/aptu_mac.sv -----
// multiply, sum, shift and saturate pipeline of the affine point transform unit
`timescale 1ns / 1ps
`include "affine_point_transform_unit_defines.svh"
module aptu_mac
    import aptu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s1_valid,
    output logic     o_s1_ready,
    input  t_issue   i_s1,
    input  t_word    i_word,
    output logic     o_res_valid,
    input  logic     i_res_ready,
    output t_out_req o_res
);

    logic                       r_s2_valid;
    logic signed [PROD_W-1:0]   r_s2_prod [MAX_DIMS];
    logic signed [COEF_W-1:0]   r_s2_trans;
    logic [COL_W-1:0]           r_s2_col;
    logic                       r_s2_last;

    logic                       r_s3_valid;
    logic signed [SUM_W-1:0]    r_s3_sum;
    logic signed [COEF_W-1:0]   r_s3_trans;
    logic [COL_W-1:0]           r_s3_col;
    logic                       r_s3_last;

    logic                       r_out_valid;
    t_out_req                   r_out;

    logic                       en2;
    logic                       en3;
    logic                       en4;
    logic signed [PROD_W-1:0]   n_prod [MAX_DIMS];
    logic signed [SUM_W-1:0]    n_sum;
    logic signed [SUM_W-1:0]    shifted;
    logic signed [TOT_W-1:0]    total;
    logic                       fits;
    t_out_req                   n_out;

    assign en4 = !r_out_valid || i_res_ready;
    assign en3 = !r_s3_valid || en4;
    assign en2 = !r_s2_valid || en3;
    assign o_s1_ready = en2;

    always_comb begin
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        for (int k = 0; k < MAX_DIMS; k++) begin
            a = i_s1.comp[k];
            b = i_word[k];
            if (DIM_W'(k) < i_s1.id) begin
                n_prod[k] = a * b;
            end else begin
                n_prod[k] = '0;
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < MAX_DIMS; k++) begin
            n_sum = n_sum + SUM_W'(r_s2_prod[k]);
        end
    end

    always_comb begin
        shifted = r_s3_sum >>> FRAC_BITS;
        total   = TOT_W'(shifted) + TOT_W'(r_s3_trans);
        fits    = (total == TOT_W'(signed'(total[COEF_W-1:0])));
        n_out.column    = r_s3_col;
        n_out.last      = r_s3_last;
        n_out.saturated = !fits;
        if (fits) begin
            n_out.result_value = total[COEF_W-1:0];
        end else if (total[TOT_W-1]) begin
            n_out.result_value = RES_MIN;
        end else begin
            n_out.result_value = RES_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en2) begin
                r_s2_valid <= i_s1_valid;
            end
            if (en3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (en4) begin
                r_out_valid <= r_s3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && i_s1_valid) begin
            r_s2_prod  <= n_prod;
            r_s2_trans <= i_word[i_s1.id];
            r_s2_col   <= i_s1.col;
            r_s2_last  <= i_s1.last;
        end
        if (en3 && r_s2_valid) begin
            r_s3_sum   <= n_sum;
            r_s3_trans <= r_s2_trans;
            r_s3_col   <= r_s2_col;
            r_s3_last  <= r_s2_last;
        end
        if (en4 && r_s3_valid) begin
            r_out <= n_out;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    `APTU_ASSERT_IMPLY(a_sat_clips, r_out_valid && r_out.saturated, r_out.result_value == RES_MAX || r_out.result_value == RES_MIN)

endmodule

// ----- rtl/affine_point_transform_unit.sv -----
// a point request passes the request register, read stage, multiply, sum and output registers
// before its first result; one result per cycle while the output is not stalled; a point issues
// its columns one by one through the single read port of the coefficient store; a load reads, then writes back
// reset: in_dims and out_dims return to 3, every coefficient reads as zero through
// per-column valid flags; no clearing pass, requests are taken right after reset
// affine point transform unit top level: config, coefficient store and read stage
`timescale 1ns / 1ps
`include "affine_point_transform_unit_defines.svh"
module affine_point_transform_unit
    import aptu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    input  t_in_req              i_req,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output t_out_req             o_res,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    logic [DIM_W-1:0]    r_in_dims;
    logic [DIM_W-1:0]    r_out_dims;
    logic [MAX_DIMS-1:0] r_col_valid;
    logic                r_s1_valid;
    t_issue              r_s1;
    logic                r_s1_wv;

    logic                go;
    logic                issue_ok;
    logic                en1;
    logic                mac_ready;
    t_issue              iss;
    logic [WORD_W-1:0]   rd_data;
    t_word               word;
    t_word               wr_word;
    logic                wr_en;
    logic                load_in_range;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_dims  <= DIMS_RESET;
            r_out_dims <= DIMS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IN_DIMS:  r_in_dims  <= i_cfg_data;
                CFG_OUT_DIMS: r_out_dims <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign issue_ok = !r_s1_valid || (!r_s1.load && mac_ready);
    assign en1      = !r_s1_valid || r_s1.load || mac_ready;

    aptu_issue u_issue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .i_in_dims   (r_in_dims),
        .i_out_dims  (r_out_dims),
        .i_issue_ok  (issue_ok),
        .o_go        (go),
        .o_iss       (iss)
    );

    assign word = r_s1_wv ? t_word'(rd_data) : '0;

    assign load_in_range = (r_s1.row <= ROW_W'(MAX_DIMS))
                        && ((COL_W + 1)'(r_s1.col) < (COL_W + 1)'(MAX_DIMS));
    assign wr_en = r_s1_valid && r_s1.load && load_in_range;

    always_comb begin
        for (int r = 0; r < NROWS; r++) begin
            wr_word[r] = (r_s1.row == ROW_W'(r)) ? r_s1.value : word[r];
        end
    end

    aptu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_DIMS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1.col),
        .i_wr_data (WORD_W'(wr_word)),
        .i_rd_en   (go),
        .i_rd_addr (iss.col),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_col_valid <= '0;
        end else begin
            if (en1) begin
                r_s1_valid <= go;
            end
            if (wr_en) begin
                r_col_valid[r_s1.col] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_s1    <= iss;
            r_s1_wv <= r_col_valid[iss.col];
        end
    end

    aptu_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1_valid  (r_s1_valid && !r_s1.load),
        .o_s1_ready  (mac_ready),
        .i_s1        (r_s1),
        .i_word      (word),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

    `APTU_ASSERT_IMPLY(a_no_rw_overlap, wr_en, !go)
    `APTU_ASSERT_NEXT(a_s1_holds, r_s1_valid && !r_s1.load && !mac_ready, r_s1_valid && $stable(r_s1) && $stable(rd_data))

endmodule
